// ===== rtl/core/apg_pkg.sv =====
// Shared widths, queue sizing and the command type of the partition generator.
package apg_pkg;

   // Fixed field widths of the request/response beats
   localparam int VALUE_W = 7;
   localparam int POS_W   = 6;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
   localparam int Q_CNT_W     = Q_PTR_W + 1;

   // One classified request as it travels from front to back
   typedef struct packed {
      logic restart;
   } cmd_type;

endpackage

// ===== rtl/core/ascending_partition_generator_top.sv =====
// Sequence: setup after acceptance (shorter when the inner loop resumes), the equal parts filled
//   one by one, one or two store writes, then one beat per part, each through the read stage and output register.
// Requests: one is worked at a time; the parts RAM has a single write port and a single read port.
// Reset: synchronous; total returns to 1, the generator to all ones, store valid
//   bits clear in the same cycle, and the command queue and output stage empty.
module ascending_partition_generator_top #(
   parameter int MAX_TOTAL = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [apg_pkg::VALUE_W-1:0] csr_wr_data,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_restart,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [apg_pkg::VALUE_W-1:0] rsp_part_value,
   output logic [apg_pkg::POS_W-1:0]   rsp_part_position,
   output logic                        rsp_last_part,
   output logic                        rsp_final_partition,
   output logic                        rsp_exhausted
);
   import apg_pkg::*;

   logic    q_valid;
   logic    q_pop;
   cmd_type q_item;

   // Intake and command queue
   apg_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_restart (req_restart),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop)
   );

   // Generator and part streaming
   apg_back #(
      .MAX_TOTAL (MAX_TOTAL)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .q_valid             (q_valid),
      .q_item              (q_item),
      .q_pop               (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_part_value      (rsp_part_value),
      .rsp_part_position   (rsp_part_position),
      .rsp_last_part       (rsp_last_part),
      .rsp_final_partition (rsp_final_partition),
      .rsp_exhausted       (rsp_exhausted)
   );

endmodule

// ===== rtl/core/apg_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module apg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port: hold the last word while the read enable is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/apg_front.sv =====
// Request intake: accepts beats, classifies them and queues them for the back end.
module apg_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic            req_restart,
   output logic            q_valid,
   output apg_pkg::cmd_type q_item,
   input  logic            q_pop
);
   import apg_pkg::*;

   cmd_type              item_ff [QUEUE_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;
   logic                 push;
   cmd_type              new_item;

   // Accept while there is room in the queue
   assign req_ready = (count_ff != Q_CNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != '0);
   assign q_item    = item_ff[rd_ptr_ff];

   // Classify the beat
   always_comb begin
      new_item         = '0;
      new_item.restart = req_restart;
   end

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the queued command
   always_ff @(posedge clock) begin
      if (push) begin
         item_ff[wr_ptr_ff] <= new_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= Q_CNT_W'(QUEUE_DEPTH))
      else $error("command queue overfilled");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> count_ff != '0)
      else $error("pop from empty command queue");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      push && !q_pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("command queue count did not advance on push");

endmodule

// ===== rtl/core/apg_back.sv =====
// Generator back end: runs the ascending-composition steps on the parts RAM and
// streams the resulting partition one part per beat.
module apg_back #(
   parameter int MAX_TOTAL = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [apg_pkg::VALUE_W-1:0] csr_wr_data,
   input  logic                        q_valid,
   input  apg_pkg::cmd_type            q_item,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [apg_pkg::VALUE_W-1:0] rsp_part_value,
   output logic [apg_pkg::POS_W-1:0]   rsp_part_position,
   output logic                        rsp_last_part,
   output logic                        rsp_final_partition,
   output logic                        rsp_exhausted
);
   import apg_pkg::*;

   localparam int STORE_DEPTH = MAX_TOTAL + 1;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam logic [VALUE_W-1:0] MAX_V   = VALUE_W'(MAX_TOTAL);
   localparam logic [VALUE_W:0]   DEPTH_W = (VALUE_W + 1)'(STORE_DEPTH);

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_DECIDE = 8'b0000_0010,
      S_FETCH  = 8'b0000_0100,
      S_LOOP   = 8'b0000_1000,
      S_TAIL   = 8'b0001_0000,
      S_TAIL2  = 8'b0010_0000,
      S_EMIT   = 8'b0100_0000,
      S_EXH    = 8'b1000_0000
   } state_type;

   state_type            state_ff, state_in;
   logic [VALUE_W-1:0]   total_ff, total_in;
   logic [VALUE_W-1:0]   level_ff, level_in;
   logic [VALUE_W-1:0]   low_ff, low_in;
   logic [VALUE_W-1:0]   rem_ff, rem_in;
   logic                 inner_ff, inner_in;
   logic                 finished_ff, finished_in;
   logic [STORE_DEPTH-1:0] valid_ff, valid_in;
   logic [VALUE_W:0]     x_ff, x_in;
   logic [VALUE_W-1:0]   y_ff, y_in;
   logic [VALUE_W-1:0]   k_ff, k_in;
   logic [VALUE_W-1:0]   cnt_ff, cnt_in;
   logic [VALUE_W-1:0]   ptr_ff, ptr_in;
   logic                 fin_run_ff, fin_run_in;
   logic                 rd_hit_ff, rd_hit_in;

   logic                 s1_valid_ff, s1_valid_in;
   logic [POS_W-1:0]     s1_pos_ff, s1_pos_in;
   logic                 s1_last_ff, s1_last_in;
   logic                 s1_final_ff, s1_final_in;
   logic                 s1_exh_ff, s1_exh_in;

   logic                 out_valid_ff, out_valid_in;
   logic [VALUE_W-1:0]   out_value_ff;
   logic [POS_W-1:0]     out_pos_ff;
   logic                 out_last_ff, out_final_ff, out_exh_ff;

   logic                 s1_move, s1_free, issue;
   logic                 begin_run;
   logic [VALUE_W-1:0]   begin_total;
   logic                 wr_req, ram_we, ram_re;
   logic [VALUE_W:0]     wr_addr_full;
   logic [VALUE_W-1:0]   wr_data;
   logic [VALUE_W-1:0]   rd_addr_full;
   logic                 rd_in_range;
   logic [VALUE_W-1:0]   ram_rdata, rd_val;
   logic [VALUE_W-1:0]   sat_total;
   logic [VALUE_W+1:0]   sum_xy;
   logic [VALUE_W:0]     run_len;
   logic [VALUE_W:0]     k_plus1;

   // Saturate the written total into 1..MAX_TOTAL
   always_comb begin
      if (csr_wr_data == '0) begin
         sat_total = VALUE_W'(1);
      end else if (csr_wr_data > MAX_V) begin
         sat_total = MAX_V;
      end else begin
         sat_total = csr_wr_data;
      end
   end

   // Output stage handshake
   assign s1_move = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign s1_free = !s1_valid_ff || s1_move;
   assign issue   = (state_ff == S_EMIT) && (ptr_ff < cnt_ff) && s1_free;

   assign rd_val  = rd_hit_ff ? ram_rdata : '0;
   assign sum_xy  = {1'b0, x_ff} + {2'b00, y_ff};
   assign k_plus1 = {1'b0, k_ff} + 1'b1;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      total_in     = total_ff;
      level_in     = level_ff;
      low_in       = low_ff;
      rem_in       = rem_ff;
      inner_in     = inner_ff;
      finished_in  = finished_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      k_in         = k_ff;
      cnt_in       = cnt_ff;
      ptr_in       = ptr_ff;
      fin_run_in   = fin_run_ff;
      q_pop        = 1'b0;
      begin_run    = 1'b0;
      begin_total  = total_ff;
      wr_req       = 1'b0;
      wr_addr_full = {1'b0, k_ff};
      wr_data      = x_ff[VALUE_W-1:0];
      rd_addr_full = ptr_ff;
      ram_re       = 1'b0;
      run_len      = '0;

      // Configuration write restarts from the new total
      if (csr_wr_en) begin
         total_in    = sat_total;
         begin_run   = 1'b1;
         begin_total = sat_total;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               state_in = S_DECIDE;
               if (q_item.restart) begin
                  begin_run = 1'b1;
               end
            end
         end
         S_DECIDE: begin
            if (finished_ff || level_ff == '0) begin
               state_in = S_EXH;
            end else if (inner_ff) begin
               x_in     = {1'b0, low_ff};
               y_in     = rem_ff;
               k_in     = level_ff;
               state_in = S_TAIL;
            end else begin
               // Fetch the last fixed part
               rd_addr_full = level_ff - 1'b1;
               ram_re       = 1'b1;
               y_in         = rem_ff;
               k_in         = level_ff - 1'b1;
               state_in     = S_FETCH;
            end
         end
         S_FETCH: begin
            x_in     = {1'b0, rd_val} + 1'b1;
            inner_in = 1'b1;
            state_in = S_LOOP;
         end
         S_LOOP: begin
            // Fill equal parts while twice the part still fits
            if (({x_ff, 1'b0} <= {2'b00, y_ff}) && ({1'b0, k_ff} < DEPTH_W)) begin
               wr_req       = 1'b1;
               wr_addr_full = {1'b0, k_ff};
               wr_data      = x_ff[VALUE_W-1:0];
               y_in         = y_ff - x_ff[VALUE_W-1:0];
               k_in         = k_ff + 1'b1;
            end else begin
               state_in = S_TAIL;
            end
         end
         S_TAIL: begin
            wr_req       = 1'b1;
            wr_addr_full = {1'b0, k_ff};
            level_in     = k_ff;
            ptr_in       = '0;
            if ({1'b0, y_ff} >= x_ff) begin
               wr_data    = x_ff[VALUE_W-1:0];
               low_in     = x_ff[VALUE_W-1:0] + 1'b1;
               rem_in     = y_ff - 1'b1;
               fin_run_in = 1'b0;
               run_len    = {1'b0, k_ff} + (VALUE_W + 1)'(2);
               state_in   = S_TAIL2;
            end else begin
               wr_data     = sum_xy[VALUE_W-1:0];
               rem_in      = sum_xy[VALUE_W-1:0] - 1'b1;
               low_in      = x_ff[VALUE_W-1:0];
               inner_in    = 1'b0;
               finished_in = (k_ff == '0);
               fin_run_in  = (k_ff == '0);
               run_len     = k_plus1;
               state_in    = S_EMIT;
            end
            if (run_len > {1'b0, MAX_V}) begin
               cnt_in = MAX_V;
            end else begin
               cnt_in = run_len[VALUE_W-1:0];
            end
         end
         S_TAIL2: begin
            wr_req       = 1'b1;
            wr_addr_full = k_plus1;
            wr_data      = y_ff;
            state_in     = S_EMIT;
         end
         S_EMIT: begin
            if (issue) begin
               ram_re       = 1'b1;
               rd_addr_full = ptr_ff;
               ptr_in       = ptr_ff + 1'b1;
            end
            // Drop back once the last part has left the read stage
            if (ptr_ff == cnt_ff && (!s1_valid_ff || s1_move)) begin
               state_in = S_IDLE;
            end
         end
         S_EXH: begin
            if (s1_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Reset the generator to the first partition
      if (begin_run) begin
         level_in    = VALUE_W'(1);
         low_in      = '0;
         rem_in      = begin_total - 1'b1;
         inner_in    = 1'b0;
         finished_in = 1'b0;
      end
   end

   // RAM port qualification and valid bits
   assign ram_we      = wr_req && (wr_addr_full < DEPTH_W);
   assign rd_in_range = ({1'b0, rd_addr_full} < DEPTH_W);
   assign rd_hit_in   = rd_in_range && valid_ff[rd_addr_full[ADDR_W-1:0]];

   always_comb begin
      valid_in = valid_ff;
      if (begin_run) begin
         valid_in = '0;
      end else if (ram_we) begin
         valid_in[wr_addr_full[ADDR_W-1:0]] = 1'b1;
      end
   end

   // Read stage and output register
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_pos_in   = s1_pos_ff;
      s1_last_in  = s1_last_ff;
      s1_final_in = s1_final_ff;
      s1_exh_in   = s1_exh_ff;
      if (issue) begin
         s1_valid_in = 1'b1;
         s1_pos_in   = ptr_ff[POS_W-1:0];
         s1_last_in  = (ptr_ff + 1'b1 == cnt_ff);
         s1_final_in = fin_run_ff;
         s1_exh_in   = 1'b0;
      end else if (state_ff == S_EXH && s1_free) begin
         s1_valid_in = 1'b1;
         s1_pos_in   = '0;
         s1_last_in  = 1'b1;
         s1_final_in = 1'b0;
         s1_exh_in   = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (s1_move) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         total_ff     <= VALUE_W'(1);
         level_ff     <= VALUE_W'(1);
         low_ff       <= '0;
         rem_ff       <= '0;
         inner_ff     <= 1'b0;
         finished_ff  <= 1'b0;
         valid_ff     <= '0;
         cnt_ff       <= '0;
         ptr_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         level_ff     <= level_in;
         low_ff       <= low_in;
         rem_ff       <= rem_in;
         inner_ff     <= inner_in;
         finished_ff  <= finished_in;
         valid_ff     <= valid_in;
         cnt_ff       <= cnt_in;
         ptr_ff       <= ptr_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      y_ff        <= y_in;
      k_ff        <= k_in;
      fin_run_ff  <= fin_run_in;
      s1_pos_ff   <= s1_pos_in;
      s1_last_ff  <= s1_last_in;
      s1_final_ff <= s1_final_in;
      s1_exh_ff   <= s1_exh_in;
      if (ram_re) begin
         rd_hit_ff <= rd_hit_in;
      end
      if (s1_move) begin
         out_value_ff <= s1_exh_ff ? '0 : rd_val;
         out_pos_ff   <= s1_pos_ff;
         out_last_ff  <= s1_last_ff;
         out_final_ff <= s1_final_ff;
         out_exh_ff   <= s1_exh_ff;
      end
   end

   apg_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (STORE_DEPTH)
   ) u_parts_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_addr_full[ADDR_W-1:0]),
      .wr_data (wr_data),
      .rd_en   (ram_re),
      .rd_addr (rd_addr_full[ADDR_W-1:0]),
      .rd_data (ram_rdata)
   );

   assign rsp_valid           = out_valid_ff;
   assign rsp_part_value      = out_value_ff;
   assign rsp_part_position   = out_pos_ff;
   assign rsp_last_part       = out_last_ff;
   assign rsp_final_partition = out_final_ff;
   assign rsp_exhausted       = out_exh_ff;

   a_fetch_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FETCH |-> !s1_valid_ff || s1_exh_ff)
      else $error("part fetch would clobber a pending read beat");

   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT |-> ptr_ff <= cnt_ff)
      else $error("emit pointer ran past run length");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_move |=> s1_valid_ff && $stable(s1_pos_ff))
      else $error("read stage overwritten while stalled");

   a_exh_shape: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_exh_ff |-> out_last_ff && !out_final_ff)
      else $error("exhausted beat with wrong run flags");

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the ascending partition generator.
`timescale 1ns / 100ps

module testbench;
   import apg_pkg::*;

   localparam int MAX_TOTAL      = 64;
   localparam int STORE_DEPTH    = MAX_TOTAL + 1;
   localparam int IDLE_PCT       = 15;
   localparam int SETTLE_CYCLES  = 150;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SWEEP_ITEMS    = 250;
   localparam int MAX_SHOWN      = 10;

   // Resume point of the enumeration loops
   typedef enum bit {OUTER_LOOP, INNER_LOOP} gen_phase_type;

   // One response beat: a single part of a partition run
   typedef struct {
      logic [VALUE_W-1:0] value;
      logic [POS_W-1:0]   position;
      logic               last_part;
      logic               final_partition;
      logic               exhausted;
   } part_beat_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_wr_en = 1'b0;
   logic [VALUE_W-1:0] csr_wr_data = '0;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_restart = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [VALUE_W-1:0] rsp_part_value;
   logic [POS_W-1:0]   rsp_part_position;
   logic               rsp_last_part;
   logic               rsp_final_partition;
   logic               rsp_exhausted;

   // Generator state mirrored by the predictor
   int unsigned   total_reg;
   int unsigned   parts_store [STORE_DEPTH];
   int unsigned   level;
   int unsigned   low_part;
   int unsigned   remainder;
   gen_phase_type gen_phase;
   bit            gen_done;

   part_beat_type expected_parts[$];
   bit           no_idle = 1'b0;
   int           requests_sent = 0;
   int           beats_checked = 0;
   int           exhausted_seen = 0;
   int           final_runs_seen = 0;
   int           mismatches = 0;
   int           stall_cycles = 0;

   ascending_partition_generator_top #(
      .MAX_TOTAL(MAX_TOTAL)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_restart        (req_restart),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_part_value     (rsp_part_value),
      .rsp_part_position  (rsp_part_position),
      .rsp_last_part      (rsp_last_part),
      .rsp_final_partition(rsp_final_partition),
      .rsp_exhausted      (rsp_exhausted)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------
   // Partition predictor
   // ---------------------------------------------------------------
   function automatic int unsigned store_read(int unsigned idx);
      return (idx < STORE_DEPTH) ? parts_store[idx] : 0;
   endfunction

   function automatic void store_write(int unsigned idx, int unsigned val);
      if (idx < STORE_DEPTH) parts_store[idx] = val & 8'h7F;
   endfunction

   function automatic int unsigned clamped_total();
      int unsigned t;
      t = total_reg & 8'h7F;
      if (t == 0) t = 1;
      if (t > MAX_TOTAL) t = MAX_TOTAL;
      return t;
   endfunction

   function automatic void start_enumeration();
      foreach (parts_store[i]) parts_store[i] = 0;
      level     = 1;
      low_part  = 0;
      remainder = clamped_total() - 1;
      gen_phase = OUTER_LOOP;
      gen_done  = 1'b0;
   endfunction

   // Queue the beats of one partition run from the store
   function automatic void queue_run(int unsigned count, bit is_final);
      part_beat_type b;
      if (count > MAX_TOTAL) count = MAX_TOTAL;
      for (int unsigned p = 0; p < count; p++) begin
         b.value           = VALUE_W'(store_read(p));
         b.position        = p[POS_W-1:0];
         b.last_part       = (p + 1 == count);
         b.final_partition = is_final;
         b.exhausted       = 1'b0;
         expected_parts.push_back(b);
      end
   endfunction

   // Advance the generator by one request and queue what it emits
   function automatic void predict_partition(bit restart);
      int unsigned   x, y, k;
      part_beat_type b;
      if (restart) start_enumeration();
      if (gen_done || level == 0) begin
         b.value           = '0;
         b.position        = '0;
         b.last_part       = 1'b1;
         b.final_partition = 1'b0;
         b.exhausted       = 1'b1;
         expected_parts.push_back(b);
         return;
      end
      x = low_part;
      y = remainder;
      k = level;
      if (gen_phase != INNER_LOOP) begin
         x = store_read(k - 1) + 1;
         k = k - 1;
         while (2 * x <= y && k < STORE_DEPTH) begin
            store_write(k, x);
            y = y - x;
            k = k + 1;
         end
         gen_phase = INNER_LOOP;
      end
      if (x <= y) begin
         store_write(k, x);
         store_write(k + 1, y);
         low_part  = (x + 1) & 8'h7F;
         remainder = (y - 1) & 8'h7F;
         level     = k & 8'h7F;
         queue_run(k + 2, 1'b0);
      end else begin
         store_write(k, x + y);
         remainder = (x + y - 1) & 8'h7F;
         low_part  = x & 8'h7F;
         level     = k & 8'h7F;
         gen_phase = OUTER_LOOP;
         if (k == 0) gen_done = 1'b1;
         queue_run(k + 1, k == 0);
      end
   endfunction

   // ---------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------
   // Stall the response side at random unless a no-idle stretch is running
   always @(negedge clock) begin
      rsp_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
   end

   // Send one request beat; enter and leave at a falling edge
   task automatic send_request(bit restart);
      while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_restart <= restart;
      do @(posedge clock); while (!req_ready);
      predict_partition(restart);
      requests_sent++;
      @(negedge clock);
   endtask

   // Drop valid, wait for every expected beat, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (expected_parts.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Write the total register; the block is idle here
   task automatic write_total(logic [VALUE_W-1:0] val);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= val;
      total_reg    = 32'(val);
      start_enumeration();
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // ---------------------------------------------------------------
   // Response checker
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      part_beat_type exp_b;
      if (!reset && rsp_valid && rsp_ready) begin
         beats_checked++;
         if (rsp_exhausted) exhausted_seen++;
         if (rsp_final_partition && rsp_last_part) final_runs_seen++;
         if (expected_parts.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
               $display("[%0t] unexpected beat: value=%0d pos=%0d last=%0b final=%0b exh=%0b",
                        $realtime, rsp_part_value, rsp_part_position, rsp_last_part,
                        rsp_final_partition, rsp_exhausted);
         end else begin
            exp_b = expected_parts.pop_front();
            if (rsp_part_value !== exp_b.value || rsp_part_position !== exp_b.position ||
                rsp_last_part !== exp_b.last_part ||
                rsp_final_partition !== exp_b.final_partition ||
                rsp_exhausted !== exp_b.exhausted) begin
               mismatches++;
               if (mismatches <= MAX_SHOWN)
                  $display("[%0t] mismatch: exp value=%0d pos=%0d last=%0b final=%0b exh=%0b",
                           $realtime, exp_b.value, exp_b.position, exp_b.last_part,
                           exp_b.final_partition, exp_b.exhausted, "\n",
                           "            got value=%0d pos=%0d last=%0b final=%0b exh=%0b",
                           rsp_part_value, rsp_part_position, rsp_last_part,
                           rsp_final_partition, rsp_exhausted);
            end
         end
      end
   end

   // Count cycles with work pending and no beat moving
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (!req_valid && expected_parts.size() == 0)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no progress for %0d cycles", stall_cycles);
         $display("Verification failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------
   // Default total of one: single part, then exhausted, then restart
   task automatic test_reset_state();
      send_request(1'b0);
      send_request(1'b0);
      send_request(1'b0);
      send_request(1'b1);
      drain();
   endtask

   // Zero, saturated and largest totals; the first run of 64 ones is the widest
   task automatic test_total_extremes();
      write_total(7'd0);
      send_request(1'b0);
      send_request(1'b0);
      drain();
      write_total(7'd127);
      send_request(1'b0);
      send_request(1'b0);
      send_request(1'b0);
      drain();
      write_total(7'd65);
      send_request(1'b0);
      drain();
      write_total(7'd64);
      send_request(1'b0);
      send_request(1'b1);
      drain();
   endtask

   // Walk all partitions of 4, past the end, with a restart in the middle
   task automatic test_small_enumeration();
      write_total(7'd4);
      repeat (3) send_request(1'b0);
      send_request(1'b1);
      repeat (6) send_request(1'b0);
      drain();
   endtask

   // Full enumeration of 7 with both sides always ready
   task automatic test_back_to_back();
      write_total(7'd7);
      no_idle = 1'b1;
      repeat (17) send_request(1'b0);
      send_request(1'b1);
      repeat (4) send_request(1'b0);
      no_idle = 1'b0;
      drain();
   endtask

   // Hold the sender until every beat is back, then resume the same enumeration
   task automatic test_drain_pause();
      write_total(7'd9);
      repeat (5) send_request(1'b0);
      req_valid <= 1'b0;
      @(negedge clock);
      while (expected_parts.size() != 0) @(negedge clock);
      repeat ($urandom_range(1, 8)) @(negedge clock);
      repeat (5) send_request(1'b0);
      drain();
   endtask

   // Random totals, mostly small enough to enumerate fully; occasional restarts
   task automatic test_random_sweep();
      int          target;
      int          seg_len;
      int unsigned pick;
      logic [VALUE_W-1:0] new_total;
      target = requests_sent + SWEEP_ITEMS;
      while (requests_sent < target) begin
         pick = $urandom_range(99);
         if (pick < 70)      new_total = VALUE_W'($urandom_range(1, 9));
         else if (pick < 90) new_total = VALUE_W'($urandom_range(10, 20));
         else                new_total = VALUE_W'($urandom_range(0, 127));
         write_total(new_total);
         seg_len = $urandom_range(5, 60);
         for (int n = 0; n < seg_len && requests_sent < target; n++) begin
            if (gen_done && $urandom_range(99) < 40) break;
            send_request($urandom_range(99) < 6);
         end
         drain();
      end
   endtask

   initial begin
      total_reg = 1;
      start_enumeration();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_state();
      test_total_extremes();
      test_small_enumeration();
      test_back_to_back();
      test_drain_pause();
      test_random_sweep();

      if (expected_parts.size() != 0) begin
         mismatches += expected_parts.size();
         $display("%0d expected beats never arrived", expected_parts.size());
      end
      $display("Covered %0d requests and %0d part beats over totals 0..127,",
               requests_sent, beats_checked);
      $display("  with %0d complete enumerations and %0d exhausted replies; %0d mismatches.",
               final_runs_seen, exhausted_seen, mismatches);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
